@@ rtl/sig_pkg.sv @@
package sig_pkg;

  // Widths of the words on the two channels
  localparam int XW = 16;
  localparam int YW = 16;

  // Fixed-point constants (Q5.10 input, Q16.24 exponential, Q0.16 result)
  localparam int FRAC    = 24;
  localparam int EW      = 40;              // exponential word
  localparam int RW      = EW + 1;          // divisor / remainder word
  localparam int CLAMP   = 16384;           // 16.0 in Q5.10
  localparam int BAND    = 1249;            // 1.22 in Q5.10, truncated
  localparam int SLOPE   = 15142;           // 0.23105 in Q0.16, truncated
  localparam int RND     = 512;
  localparam int HALF    = 32768;           // 0.5 in Q0.16
  localparam int DIV_SH  = 9;               // x/32 in Q16.24 from Q5.10

  localparam logic [RW-1:0] ONE_E   = RW'(1) << FRAC;
  localparam logic [EW-1:0] E_SAT   = {EW{1'b1}};

  // Pipeline layout: entry, squarings, divisor setup, one quotient bit a stage
  localparam int NSQ  = 5;
  localparam int NDIV = YW;
  localparam int NST  = 1 + NSQ + 1 + NDIV;
  localparam int LAST = NST - 1;

  typedef struct packed {
    logic                  band;
    logic signed [XW-1:0]  xc;
    logic        [YW-1:0]  ly;
    logic        [RW-1:0]  rem;
    logic        [RW-1:0]  d;
    logic        [YW-1:0]  q;
  } stage_t;

endpackage

@@ rtl/sig_stream_if.sv @@
interface sig_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       x;

  modport source (output valid, output x, input ready);
  modport sink   (input valid, input x, output ready);
endinterface

interface sig_out_if;
  logic                     valid;
  logic                     ready;
  logic        [15:0]       y;

  modport source (output valid, output y, input ready);
  modport sink   (input valid, input y, output ready);
endinterface

@@ rtl/sigmoid_approximation.sv @@
// Logistic sigmoid approximation on a stream of signed Q5.10 samples.
// in_chan carries one sample word (x) a transfer; out_chan carries one
// unsigned Q0.16 result word (y) for every sample, in order.
// Samples inside +-1.22 take a straight line; others go through
// e = (1 + x/32)^32 by five squarings and then e/(e+1) by restoring division.
// The pipeline is 23 register stages: one clamp stage, five squaring stages
// (one 32x32 multiplier each), a divisor stage and sixteen divide stages
// (one 42-bit compare and subtract each, one quotient bit per stage).
// Throughput is one word per cycle unless the receiver stalls; in_chan.ready
// is high whenever the last stage is empty or being taken.
// When the receiver stalls with a word in the last stage, the whole pipeline
// holds and in_chan.ready drops; nothing is lost or repeated. Reset (rst_n
// low, synchronous) empties every stage; there is no other state.
module sigmoid_approximation (
  input  logic      clk,
  input  logic      rst_n,
  sig_in_if.sink    in_chan,
  sig_out_if.source out_chan
);
  import sig_pkg::*;

  stage_t          st_r   [NST];
  stage_t          st_nxt [NST];
  logic [NST-1:0]  vld_r;
  logic            adv;

  assign adv           = !vld_r[LAST] || out_chan.ready;
  assign in_chan.ready = adv;
  assign out_chan.valid = vld_r[LAST];
  assign out_chan.y    = st_r[LAST].band ? st_r[LAST].ly : st_r[LAST].q;

  always_comb begin
    logic signed [XW-1:0] xc;
    logic signed [RW-1:0] xs;
    logic        [EW-1:0] sq_e;
    logic        [63:0]   sq_p;
    logic signed [31:0]   lp;
    logic        [RW:0]   t;
    logic                 qb;

    // entry: clamp, band test, start value of the exponential
    xc = in_chan.x;
    if (in_chan.x > XW'(CLAMP))
      xc = XW'(CLAMP);
    else if (in_chan.x < -XW'(CLAMP))
      xc = -XW'(CLAMP);
    xs = {{(RW-XW){xc[XW-1]}}, xc};
    st_nxt[0].band = (xc >= -XW'(BAND)) && (xc <= XW'(BAND));
    st_nxt[0].xc   = xc;
    st_nxt[0].ly   = '0;
    st_nxt[0].rem  = ONE_E + RW'(xs <<< DIV_SH);
    st_nxt[0].d    = '0;
    st_nxt[0].q    = '0;

    for (int s = 1; s < NST; s++) begin
      st_nxt[s] = st_r[s-1];
      sq_e = st_r[s-1].rem[EW-1:0];
      sq_p = 64'(sq_e[31:0]) * 64'(sq_e[31:0]);
      lp   = 32'(st_r[s-1].xc) * 32'(SLOPE) + 32'(RND) + 32'(HALF << 10);
      t    = {st_r[s-1].rem, 1'b0};
      qb   = (t >= {1'b0, st_r[s-1].d});
      if (s <= NSQ) begin
        // saturate once e reaches 2^32, else floor(e*e / 2^24)
        if (sq_e[EW-1:32] != '0)
          st_nxt[s].rem = {1'b0, E_SAT};
        else
          st_nxt[s].rem = {1'b0, sq_p[FRAC+EW-1:FRAC]};
        if (s == 1)
          st_nxt[s].ly = lp[YW+9:10];
      end else if (s == NSQ + 1) begin
        // remainder starts at e, which is always below the divisor
        st_nxt[s].d = {1'b0, st_r[s-1].rem[EW-1:0]} + ONE_E;
        st_nxt[s].q = '0;
      end else begin
        st_nxt[s].rem = qb ? RW'(t - {1'b0, st_r[s-1].d}) : RW'(t);
        st_nxt[s].q   = {st_r[s-1].q[YW-2:0], qb};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NST; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;

  localparam int      ITEMS_RANDOM = 1630;
  localparam int      CALM_TAIL    = 200;
  localparam int      CYCLE_LIMIT  = 500000;
  localparam int      PRINT_CAP    = 100;
  localparam int      X_CLAMP      = 16384;
  localparam int      X_BAND       = 1249;
  localparam int      LINE_SLOPE   = 15142;
  localparam int      Y_HALF       = 32768;
  localparam logic [63:0] E_ONE    = 64'd1 << 24;
  localparam logic [63:0] E_TOP    = (64'd1 << 40) - 64'd1;

  typedef struct {
    logic signed [15:0] x;
    bit                 typed;
    logic        [15:0] y;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sig_in_if  in_chan ();
  sig_out_if out_chan ();

  sigmoid_approximation u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  logic [15:0] y_pending[$];
  int          mismatches = 0;
  int          cycles     = 0;
  bit          calm       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  // line inside the band, otherwise (1 + x/32)^32 then e/(e+1)
  function automatic logic [15:0] sigmoid_q16(input logic signed [15:0] x);
    int          xc;
    int          acc;
    logic [63:0] e;
    logic [63:0] y;
    xc = x;
    if (xc > X_CLAMP) xc = X_CLAMP;
    if (xc < -X_CLAMP) xc = -X_CLAMP;
    if (xc >= -X_BAND && xc <= X_BAND) begin
      acc = xc * LINE_SLOPE + 512 + (Y_HALF << 10);
      y = 64'(acc >> 10);
    end else begin
      e = 64'(longint'(E_ONE) + longint'(xc) * 512);
      for (int i = 0; i < 5; i++) begin
        if (e >= (64'd1 << 32)) begin
          e = E_TOP;
        end else begin
          e = (e * e) >> 24;
          if (e > E_TOP) e = E_TOP;
        end
      end
      y = (e << 16) / (e + E_ONE);
    end
    if (y > 64'd65535) y = 64'd65535;
    return y[15:0];
  endfunction

  task automatic send_word(input logic signed [15:0] x, input logic [15:0] y_want);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.x     <= x;
    do @(posedge clk); while (!in_chan.ready);
    y_pending.push_back(y_want);
  endtask

  function automatic logic signed [15:0] pick_x();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 2 * X_BAND)) - X_BAND;
      3: v = ($urandom_range(0, 1) ? 1 : -1) * (X_BAND + int'($urandom_range(0, 3)) - 1);
      4, 5: v = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(X_BAND + 1, X_CLAMP));
      6: v = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(X_CLAMP - 2, 32767));
      default: v = int'($urandom_range(0, 65535));
    endcase
    return 16'(v);
  endfunction

  // receiver: stall bursts, none once the tail starts
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_out
    logic [15:0] want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (y_pending.size() == 0) begin
        report($sformatf("unexpected word y=%0d", out_chan.y));
      end else begin
        want = y_pending.pop_front();
        if (out_chan.y !== want)
          report($sformatf("y=%0d want %0d", out_chan.y, want));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    sample_row_t rows[$];
    logic [15:0] want;
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.x     = '0;

    rows = '{
      '{16'sd0,      1'b1, 16'd32768},
      '{16'sd1249,   1'b1, 16'd51237},
      '{-16'sd1249,  1'b1, 16'd14299},
      '{16'sd32767,  1'b1, 16'd65535},
      '{-16'sd32768, 1'b1, 16'd0},
      '{16'sd16384,  1'b1, 16'd65535},
      '{-16'sd16384, 1'b1, 16'd0},
      '{16'sd16385,  1'b1, 16'd65535},
      '{-16'sd16385, 1'b1, 16'd0},
      '{16'sd1,      1'b0, 16'd0},
      '{-16'sd1,     1'b0, 16'd0},
      '{16'sd1250,   1'b0, 16'd0},
      '{-16'sd1250,  1'b0, 16'd0},
      '{16'sd1248,   1'b0, 16'd0},
      '{-16'sd1248,  1'b0, 16'd0},
      '{16'sd3000,   1'b0, 16'd0},
      '{-16'sd3000,  1'b0, 16'd0},
      '{16'sd8192,   1'b0, 16'd0},
      '{-16'sd8192,  1'b0, 16'd0},
      '{16'sd12000,  1'b0, 16'd0},
      '{-16'sd12000, 1'b0, 16'd0},
      '{16'sh5555,   1'b0, 16'd0},
      '{-16'sh2aab,  1'b0, 16'd0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      want = rows[i].typed ? rows[i].y : sigmoid_q16(rows[i].x);
      send_word(rows[i].x, want);
    end

    for (int n = 0; n < ITEMS_RANDOM; n++) begin
      logic signed [15:0] x;
      if (n == ITEMS_RANDOM / 2) begin
        // drain the pipeline completely once, then restart the stream
        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (y_pending.size() != 0) @(posedge clk);
      end
      if (n == ITEMS_RANDOM - CALM_TAIL) calm = 1'b1;
      x = pick_x();
      send_word(x, sigmoid_q16(x));
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (y_pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sigmoid_approximation.f @@
rtl/sig_pkg.sv
rtl/sig_stream_if.sv
rtl/sigmoid_approximation.sv
bench/tb_top.sv
